>>> src/assert_macros.svh
// Assertion helpers, sampled on clk and held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge
`define LBED_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define LBED_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LBED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/lbed_pkg.sv
package lbed_pkg;

  localparam int PIX_W     = 8;
  localparam int HALF_W    = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = HALF_W;

  localparam logic [PIX_W-1:0]     PIX_MAX     = 8'hFF;
  localparam logic [PIX_W-1:0]     PIX_MIN     = 8'h00;
  localparam logic [HALF_W-1:0]    HALF_RESET  = 5'd8;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DILATE_MODE = 1'd1;

  // control travelling with a word from the window stage to the result stage
  typedef struct packed {
    logic valid;
    logic produce;
    logic last;
  } stage_t;

  // min (erode) or max (dilate) of two pixels
  function automatic logic [PIX_W-1:0] lbed_pick(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b,
                                                 input logic             dil);
    logic a_gt;
    a_gt = (a > b);
    if (dil) begin
      return a_gt ? a : b;
    end else begin
      return a_gt ? b : a;
    end
  endfunction

endpackage

>>> src/lbed_window.sv
module lbed_window #(
  parameter int Depth = 33,
  parameter int LenW  = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                advance,
  input  logic [lbed_pkg::PIX_W-1:0]          pixel,
  input  logic                                line_end,
  input  logic [LenW-1:0]                     len,
  output logic [Depth-1:0][lbed_pkg::PIX_W-1:0] window,
  output logic [LenW-1:0]                     fill,
  output lbed_pkg::stage_t                    stage
);
  import lbed_pkg::*;

  logic [LenW-1:0] fill_inc;
  logic [LenW-1:0] fill_next;

  assign fill_inc  = (fill == LenW'(Depth)) ? fill : fill + LenW'(1);
  assign fill_next = line_end ? '0 : fill_inc;

  // tap shift line, entry 0 newest
  always_ff @(posedge clk) begin
    if (accept) begin
      window <= {window[Depth-2:0], pixel};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      stage <= '0;
    end else if (accept) begin
      fill          <= fill_next;
      stage.valid   <= 1'b1;
      stage.produce <= (fill_inc >= len);
      stage.last    <= line_end;
    end else if (advance) begin
      stage.valid <= 1'b0;
    end
  end

endmodule

>>> src/lbed_reduce.sv
module lbed_reduce #(
  parameter int Depth = 33,
  parameter int LenW  = 6
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [Depth-1:0][lbed_pkg::PIX_W-1:0] window,
  input  lbed_pkg::stage_t                      stage,
  input  logic [LenW-1:0]                       len,
  input  logic                                  dilate_mode,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic [lbed_pkg::PIX_W-1:0]            filtered_value,
  output logic                                  last_of_line,
  output logic                                  slot_free
);
  import lbed_pkg::*;

  localparam int Leaves = 2 ** $clog2(Depth);

  logic [PIX_W-1:0] neutral;
  logic [PIX_W-1:0] node [2*Leaves-1];
  logic             load;

  assign neutral = dilate_mode ? PIX_MIN : PIX_MAX;

  // leaves: taps beyond the bar length drop out as the neutral value
  for (genvar i = 0; i < Leaves; i++) begin : g_leaf
    if (i < Depth) begin : g_tap
      assign node[Leaves-1+i] = (LenW'(i) < len) ? window[i] : neutral;
    end else begin : g_pad
      assign node[Leaves-1+i] = neutral;
    end
  end

  // heap-ordered compare tree, root at node 0
  for (genvar k = 0; k < Leaves - 1; k++) begin : g_node
    assign node[k] = lbed_pick(node[2*k+1], node[2*k+2], dilate_mode);
  end

  assign slot_free = !out_valid || !out_stall;
  assign load      = stage.valid && stage.produce && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      filtered_value <= node[0];
      last_of_line   <= stage.last;
    end
  end

endmodule

>>> src/line_bar_erode_dilate_core.sv
// Grayscale erode / dilate along a scan line with a bar of 2*H+1 pixels.
// Input channel: in_valid / in_stall carry one pixel word, line_end marking
//   the last pixel of the line (margins included in the stream).
// Output channel: out_valid / out_stall carry filtered_value (window min when
//   eroding, max when dilating) and last_of_line.
// Config: cfg_we writes cfg_data into register cfg_index (0 half_length,
//   1 dilate_mode); the user writes only while the block is idle, which the block
//   does not enforce. Other indexes ignored. Throughput: one word per cycle while
//   the output is not stalled; each word passes the window stage register, a
//   compare tree of depth ceil(log2(2*MAX_HALF_LENGTH+1)) and the output register.
// No result until 2*H+1 pixels of the line are held; line_end restarts the fill.
// Reset: fill count and all valids cleared, half_length 8, erode mode. The
//   pixel taps carry no reset, only filled taps are ever selected.
// Stall: the output register holds; words keep entering the window stage until
//   it holds one that owes a result, and in_stall is high while that word waits.
`include "assert_macros.svh"

module line_bar_erode_dilate_core #(
  parameter int MAX_HALF_LENGTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lbed_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbed_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lbed_pkg::PIX_W-1:0]       pixel,
  input  logic                             line_end,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [lbed_pkg::PIX_W-1:0]       filtered_value,
  output logic                             last_of_line
);
  import lbed_pkg::*;

  localparam int Depth = 2 * MAX_HALF_LENGTH + 1;
  localparam int LenW  = $clog2(Depth + 1);

  // config registers
  logic [HALF_W-1:0] half_length;
  logic              dilate_mode;

  logic [LenW-2:0]   eff_half;
  logic [LenW-1:0]   len;

  logic [Depth-1:0][PIX_W-1:0] window;
  logic [LenW-1:0]   fill;
  stage_t            stage;
  logic              slot_free;
  logic              s1_free;
  logic              accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_length <= HALF_RESET;
      dilate_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_LENGTH: half_length <= cfg_data;
        REG_DILATE_MODE: dilate_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // half length saturates at the build maximum
  always_comb begin
    if (32'(half_length) > 32'(MAX_HALF_LENGTH)) begin
      eff_half = (LenW-1)'(MAX_HALF_LENGTH);
    end else begin
      eff_half = (LenW-1)'(half_length);
    end
  end
  assign len = {eff_half, 1'b1};

  // window stage may move on if it is empty, owes nothing, or the output slot frees
  assign s1_free  = !stage.valid || !stage.produce || slot_free;
  assign in_stall = !s1_free;
  assign accept   = in_valid && !in_stall;

  lbed_window #(
    .Depth (Depth),
    .LenW  (LenW)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .advance  (s1_free),
    .pixel    (pixel),
    .line_end (line_end),
    .len      (len),
    .window   (window),
    .fill     (fill),
    .stage    (stage)
  );

  lbed_reduce #(
    .Depth (Depth),
    .LenW  (LenW)
  ) u_reduce (
    .clk            (clk),
    .rst            (rst),
    .window         (window),
    .stage          (stage),
    .len            (len),
    .dilate_mode    (dilate_mode),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .filtered_value (filtered_value),
    .last_of_line   (last_of_line),
    .slot_free      (slot_free)
  );

  `LBED_ASSERT_ALWAYS(a_fill_bound, fill <= LenW'(Depth), "fill count beyond window depth")
  `LBED_ASSERT_IMPLY(a_stall_cause, in_stall, stage.valid && stage.produce && out_valid && out_stall, "input stalled without a blocked result")
  `LBED_ASSERT_NEXT(a_line_clear, accept && line_end, fill == '0, "line end did not clear fill")
  `LBED_ASSERT_IMPLY(a_out_source, $rose(out_valid), $past(stage.valid && stage.produce), "result without a producing word")

endmodule
